// ----- hw/rtl/nabf_pkg.sv -----
// ----------------------------------------------------------------------------
// nabf_pkg
// Codes and controller/datapath signal groups of the nibble-assembling byte
// FIFO.
// ----------------------------------------------------------------------------
package nabf_pkg;

  // input item kinds (s_axis_tuser)
  localparam logic [1:0] OP_NIBBLE  = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // result status (m_axis_tuser)
  localparam logic [2:0] ST_HELD     = 3'd0;
  localparam logic [2:0] ST_STORED   = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_DATA     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_SESSION  = 3'd5;
  localparam logic [2:0] ST_RELEASED = 3'd6;

  localparam int unsigned NIB_W  = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned FILL_W = 10;

  // controller -> datapath
  typedef struct packed {
    logic       take_high;  // hold the high nibble
    logic       take_low;   // low nibble seen, back to expecting high
    logic       push;       // write assembled byte
    logic       rd_start;   // load the clamped read count
    logic       pop;        // consume the byte at the read pointer
    logic       set_done;
    logic       clr_done;
    logic       out_load;   // load the output register
    logic       out_data;   // result carries the fetched byte
    logic [2:0] out_status;
    logic       out_last;
  } nabf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic expect_high;
    logic session_done;
    logic fifo_full;
    logic fifo_empty;
    logic fill_one;
    logic rem_one;
    logic req_zero;
    logic byte_zero;
  } nabf_sts_t;

endpackage

// ----- hw/rtl/nabf_dpath.sv -----
// ----------------------------------------------------------------------------
// nabf_dpath
// Byte store, pointers, fill count, nibble assembly, session flag and the
// output register.
// ----------------------------------------------------------------------------
module nabf_dpath import nabf_pkg::*; #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned MAX_READ = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [NIB_W-1:0]    nibble_i,
  input  logic [CNT_W-1:0]    read_count_i,
  input  nabf_cmd_t           cmd_i,
  output nabf_sts_t           sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [BYTE_W-1:0]   out_data_o,
  output logic [2:0]          out_status_o,
  output logic                out_last_o,
  output logic [FILL_W-1:0]   out_fill_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] MAX_RD = CNT_W'(MAX_READ);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  logic [PW-1:0]     wp_q, wp_d, rp_q, rp_d, cnt_q, cnt_d;
  logic [CNT_W-1:0]  rem_q, rem_d, req_cnt;
  logic              exp_hi_q, exp_hi_d, done_q, done_d;
  logic [NIB_W-1:0]  hold_q, hold_d;
  logic [BYTE_W-1:0] wbyte;

  logic              ovalid_q, ovalid_d;
  logic [BYTE_W-1:0] odata_q;
  logic [2:0]        ostatus_q;
  logic              olast_q;
  logic [FILL_W-1:0] ofill_q;
  logic [PW+FILL_W-1:0] fill_ext;

  assign wbyte   = {hold_q, nibble_i};
  assign req_cnt = (read_count_i > MAX_RD) ? MAX_RD : read_count_i;

  always_comb begin
    wp_d     = wp_q;
    rp_d     = rp_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    exp_hi_d = exp_hi_q;
    hold_d   = hold_q;
    done_d   = done_q;
    if (cmd_i.take_high) begin
      hold_d   = nibble_i;
      exp_hi_d = 1'b0;
    end
    if (cmd_i.take_low) exp_hi_d = 1'b1;
    if (cmd_i.push) begin
      wp_d  = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.rd_start) rem_d = req_cnt;
    if (cmd_i.pop) begin
      rp_d  = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
      cnt_d = cnt_q - 1'b1;
      rem_d = rem_q - 1'b1;
    end
    if (cmd_i.set_done) done_d = 1'b1;
    if (cmd_i.clr_done) done_d = 1'b0;
  end

  // read address runs one step ahead, so rdata_q shows mem[rp_q], except right after a push writes that slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem[wp_q] <= wbyte;
    rdata_q <= mem[rp_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      cnt_q    <= '0;
      rem_q    <= '0;
      exp_hi_q <= 1'b1;
      hold_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      exp_hi_q <= exp_hi_d;
      hold_q   <= hold_d;
      done_q   <= done_d;
    end
  end

  // output register
  assign fill_ext = {{FILL_W{1'b0}}, cnt_d};

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_i.out_load)   ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      odata_q   <= cmd_i.out_data ? rdata_q : '0;
      ostatus_q <= cmd_i.out_status;
      olast_q   <= cmd_i.out_last;
      ofill_q   <= fill_ext[FILL_W-1:0];
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_data_o   = odata_q;
  assign out_status_o = ostatus_q;
  assign out_last_o   = olast_q;
  assign out_fill_o   = ofill_q;

  assign sts_o.out_free     = !ovalid_q || out_ready_i;
  assign sts_o.expect_high  = exp_hi_q;
  assign sts_o.session_done = done_q;
  assign sts_o.fifo_full    = (cnt_q == PTR_LAST);
  assign sts_o.fifo_empty   = (cnt_q == '0);
  assign sts_o.fill_one     = (cnt_q == PW'(1));
  assign sts_o.rem_one      = (rem_q == CNT_W'(1));
  assign sts_o.req_zero     = (req_cnt == '0);
  assign sts_o.byte_zero    = (rdata_q == '0);

`ifndef ASSERT_OFF
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wp_q == rp_q))
    else $error("fill count zero but pointers differ");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("push did not raise fill count");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ostatus_q == ST_DATA) |-> (odata_q != '0))
    else $error("zero byte delivered as data");
`endif

endmodule

// ----- hw/rtl/nabf_ctrl.sv -----
// ----------------------------------------------------------------------------
// nabf_ctrl
// Controller: decodes input items and sequences read bursts.
// ----------------------------------------------------------------------------
module nabf_ctrl import nabf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  nabf_sts_t  sts_i,
  output nabf_cmd_t  cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          unique case (op_i)
            OP_NIBBLE: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (sts_i.expect_high) begin
                cmd_o.take_high  = 1'b1;
                cmd_o.out_status = ST_HELD;
              end else begin
                cmd_o.take_low = 1'b1;
                if (sts_i.fifo_full) begin
                  cmd_o.out_status = ST_DROPPED;
                end else begin
                  cmd_o.push       = 1'b1;
                  cmd_o.out_status = ST_STORED;
                end
              end
            end
            OP_READ: begin
              if (sts_i.session_done) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = ST_SESSION;
              end else if (sts_i.req_zero || sts_i.fifo_empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end else begin
                cmd_o.rd_start = 1'b1;
                state_d        = S_READ;
              end
            end
            OP_RELEASE: begin
              cmd_o.clr_done   = 1'b1;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.out_status = ST_RELEASED;
            end
            default: ;  // unused code: swallowed, no result
          endcase
        end
      end
      S_READ: begin
        if (sts_i.out_free) begin
          cmd_o.pop      = 1'b1;
          cmd_o.out_load = 1'b1;
          if (sts_i.byte_zero) begin
            // terminator: consumed, not delivered
            cmd_o.set_done   = 1'b1;
            cmd_o.out_status = ST_SESSION;
            cmd_o.out_last   = 1'b1;
            state_d          = S_IDLE;
          end else begin
            cmd_o.out_data   = 1'b1;
            cmd_o.out_status = ST_DATA;
            if (sts_i.rem_one || sts_i.fill_one) begin
              cmd_o.out_last = 1'b1;
              state_d        = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_read_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !sts_i.fifo_empty)
    else $error("burst running on an empty FIFO");

  a_burst_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && state_d == S_IDLE) |-> cmd_o.out_last)
    else $error("burst ended without last");

  a_start_enters_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_start |=> (state_q == S_READ))
    else $error("read start did not enter burst");
`endif

endmodule

// ----- hw/rtl/nibble_assembling_byte_fifo.sv -----
// ----------------------------------------------------------------------------
// nibble_assembling_byte_fifo
// Packs nibble pairs into bytes, queues them, delivers them on read request.
// ----------------------------------------------------------------------------
// Each input transfer gives one result, except an unused op code (none) and
// a read request that delivers bytes: it gives one result per byte (up to
// MAX_READ), ending at the count, when the FIFO runs dry, or at a zero byte,
// which is consumed and reported as session done. Nibble, release and
// non-delivering read items can follow back to back while the output
// register drains. A delivering read gives one result per cycle while the
// output register drains; the byte store is read one address ahead.
// The FIFO holds at most DEPTH-1 bytes; no clearing pass after reset.
module nibble_assembling_byte_fifo import nabf_pkg::*; #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned MAX_READ = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [3:0] nibble, [9:4] read_count, rest 0
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [17:8] fill_level, rest 0
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast
);

  nabf_cmd_t         cmd;
  nabf_sts_t         sts;
  logic [BYTE_W-1:0] out_data;
  logic [FILL_W-1:0] out_fill;

  nabf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nabf_dpath #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .nibble_i     (s_axis_tdata[3:0]),
    .read_count_i (s_axis_tdata[9:4]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (out_data),
    .out_status_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast),
    .out_fill_o   (out_fill)
  );

  assign m_axis_tdata = {6'd0, out_fill, out_data};

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nibble-assembling byte FIFO. A clocked driver
// feeds queued items (directed corner cases, then random sequences) with
// random gaps. A mirror of the FIFO predicts every result, and a clocked
// monitor with random back-pressure compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import nabf_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;  // ignored by the block
  localparam int unsigned FIFO_SLOTS = 1024;
  localparam int unsigned READ_CAP   = 63;
  localparam int unsigned RAND_ITEMS = 235;
  localparam int unsigned IDLE_PCT   = 31;

  typedef struct packed {
    logic [1:0]       op;
    logic [NIB_W-1:0] nib;
    logic [CNT_W-1:0] cnt;
    bit               drain;  // hold off until every owed result is in
  } stim_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [2:0]        status;
    bit                last;
    logic [FILL_W-1:0] fill;
  } fifo_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [3:0] nibble, [9:4] read_count
  logic [1:0]  s_axis_tuser = '0;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] data_byte, [17:8] fill_level
  logic [2:0]  m_axis_tuser;        // [2:0] status
  logic        m_axis_tlast;

  stim_t        queued_items[$];
  fifo_result_t awaited_results[$];
  stim_t        on_bus;
  int unsigned  mismatches = 0;
  int unsigned  cyc = 0;
  wire          calm = (cyc >= 120 && cyc < 420);

  // mirror of the FIFO
  logic [BYTE_W-1:0] mirror_mem [FIFO_SLOTS];
  logic [FILL_W-1:0] wr_ptr = '0;
  logic [FILL_W-1:0] rd_ptr = '0;
  bit                want_high = 1'b1;
  logic [NIB_W-1:0]  high_hold = '0;
  bit                session_over = 1'b0;

  nibble_assembling_byte_fifo DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) cyc <= cyc + 1;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic fifo_result_t owe(input logic [BYTE_W-1:0] data,
                                       input logic [2:0] status);
    fifo_result_t r;
    r.data   = data;
    r.status = status;
    r.last   = 1'b0;
    r.fill   = wr_ptr - rd_ptr;  // pointers wrap with the slot count
    return r;
  endfunction

  // Applies one accepted item to the mirror and queues the results it owes.
  task automatic assemble_and_deliver(input stim_t it);
    fifo_result_t      batch[$];
    logic [BYTE_W-1:0] b;
    int unsigned       limit;
    bit                stop;
    case (it.op)
      OP_NIBBLE: begin
        if (want_high) begin
          high_hold = it.nib;
          want_high = 1'b0;
          batch.push_back(owe('0, ST_HELD));
        end else begin
          b = {high_hold, it.nib};
          want_high = 1'b1;
          if (FILL_W'(wr_ptr - rd_ptr) == FILL_W'(FIFO_SLOTS - 1)) begin
            batch.push_back(owe('0, ST_DROPPED));
          end else begin
            mirror_mem[wr_ptr] = b;
            wr_ptr = wr_ptr + 1'b1;
            batch.push_back(owe('0, ST_STORED));
          end
        end
      end
      OP_READ: begin
        if (session_over) begin
          batch.push_back(owe('0, ST_SESSION));
        end else begin
          limit = (it.cnt > READ_CAP) ? READ_CAP : it.cnt;
          stop = 1'b0;
          for (int unsigned i = 0; i < limit && !stop; i++) begin
            if (wr_ptr == rd_ptr) begin
              stop = 1'b1;
            end else begin
              b = mirror_mem[rd_ptr];
              rd_ptr = rd_ptr + 1'b1;
              if (b == '0) begin
                // zero byte ends the session, consumed but not delivered
                session_over = 1'b1;
                batch.push_back(owe('0, ST_SESSION));
                stop = 1'b1;
              end else begin
                batch.push_back(owe(b, ST_DATA));
              end
            end
          end
          if (batch.size() == 0) batch.push_back(owe('0, ST_EMPTY));
        end
      end
      OP_RELEASE: begin
        session_over = 1'b0;
        batch.push_back(owe('0, ST_RELEASED));
      end
      default: ;
    endcase
    if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) awaited_results.push_back(batch[i]);
  endtask

  task automatic queue_item(input logic [1:0] op, input logic [NIB_W-1:0] nib,
                            input logic [CNT_W-1:0] cnt, input bit drain = 1'b0);
    stim_t it;
    it.op    = op;
    it.nib   = nib;
    it.cnt   = cnt;
    it.drain = drain;
    queued_items.push_back(it);
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    queue_item(OP_NIBBLE, b[7:4], CNT_W'($urandom));
    queue_item(OP_NIBBLE, b[3:0], CNT_W'($urandom));
  endtask

  // driver: a new item goes out only once the current one is taken
  always @(posedge clk_i) begin : drive_proc
    bit    go;
    stim_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) assemble_and_deliver(on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        go = 1'b0;
        if (queued_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
          go = !(queued_items[0].drain && awaited_results.size() != 0);
        if (go) begin
          nxt = queued_items.pop_front();
          on_bus        <= nxt;
          s_axis_tdata  <= {6'd0, nxt.cnt, nxt.nib};
          s_axis_tuser  <= nxt.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch_proc
    fifo_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, status %0d", m_axis_tuser));
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tdata[7:0] !== want.data)
            report_mismatch($sformatf("data_byte %0h, want %0h",
                                      m_axis_tdata[7:0], want.data));
          if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast, want.last));
          if (m_axis_tdata[17:8] !== want.fill)
            report_mismatch($sformatf("fill_level %0d, want %0d",
                                      m_axis_tdata[17:8], want.fill));
          if (m_axis_tdata[23:18] !== '0)
            report_mismatch("tdata padding not zero");
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    int unsigned n_rand;
    int unsigned pick;
    // directed corners
    queue_item(OP_READ, 4'hF, 6'd0);          // zero count on empty
    queue_item(OP_READ, 4'h0, 6'd5);          // empty FIFO
    queue_item(OP_RELEASE, 4'hA, 6'd21);      // release with no session
    queue_item(OP_UNUSED, 4'hF, 6'd63);       // ignored
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'hA5);
    queue_byte(8'h12);
    queue_item(OP_READ, 4'h5, 6'd63);         // FF then zero byte ends session
    queue_item(OP_READ, 4'h0, 6'd1);          // session done
    queue_item(OP_RELEASE, 4'h0, 6'd0);
    queue_item(OP_READ, 4'h3, 6'd0);          // zero count with data held
    queue_item(OP_READ, 4'h0, 6'd1);          // A5
    queue_item(OP_READ, 4'h0, 6'd63);         // 12, then runs dry
    queue_item(OP_NIBBLE, 4'h3, 6'd42);       // high half held
    queue_item(OP_READ, 4'hC, 6'd2);          // empty mid-byte
    queue_item(OP_NIBBLE, 4'hC, 6'd0);
    queue_item(OP_READ, 4'h0, 6'd63, 1'b1);

    // random sequences
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 9) == 0) queue_byte('0);
        else queue_byte(BYTE_W'($urandom));
        n_rand += 2;
      end else if (pick < 50) begin
        queue_item(OP_NIBBLE, NIB_W'($urandom), CNT_W'($urandom));  // odd half
        n_rand++;
      end else if (pick < 80) begin
        queue_item(OP_READ, NIB_W'($urandom),
                   ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(0, 8))
                                              : CNT_W'($urandom),
                   $urandom_range(0, 99) < 4);
        n_rand++;
      end else if (pick < 95) begin
        queue_item(OP_RELEASE, NIB_W'($urandom), CNT_W'($urandom));
        n_rand++;
      end else begin
        queue_item(OP_UNUSED, NIB_W'($urandom), CNT_W'($urandom));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (queued_items.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 400000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/nabf_pkg.sv
hw/rtl/nabf_dpath.sv
hw/rtl/nabf_ctrl.sv
hw/rtl/nibble_assembling_byte_fifo.sv
test/tb_top.sv
